// ----- sv/flsa_pkg.sv -----
// Shared types and constants for the fenced linear sub-allocator.
// Holds the request and response payloads, the cell command and report structs,
// the operation, register and state codes. Depends on nothing.
package flsa_pkg;

   // Table geometry
   localparam int MAX_BUFFERS = 16;
   localparam int IDX_W       = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
   localparam int COUNT_W     = $clog2(MAX_BUFFERS + 1);

   // Fixed field widths
   localparam int OP_W         = 2;
   localparam int FENCE_W      = 64;
   localparam int SIZE_W       = 32;
   localparam int IDLE_W       = 8;
   localparam int INIT_NUM_W   = 5;
   localparam int OUT_INDEX_W  = 4;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 32;

   // Register reset values
   localparam logic [INIT_NUM_W-1:0] INIT_NUM_BUFFERS_RST = INIT_NUM_W'(4);
   localparam logic [SIZE_W-1:0]     INIT_BUFFER_SIZE_RST = SIZE_W'(65536);
   localparam logic [SIZE_W-1:0]     MIN_BUFFER_SIZE_RST  = SIZE_W'(65536);
   localparam logic [IDLE_W-1:0]     RELEASE_LATENCY_RST  = IDLE_W'(3);

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_ALLOCATE   = 2'd0,
      OP_RETIRE     = 2'd1,
      OP_INITIALIZE = 2'd2
   } flsa_op_type;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INIT_NUM_BUFFERS = 2'd0,
      CSR_INIT_BUFFER_SIZE = 2'd1,
      CSR_MIN_BUFFER_SIZE  = 2'd2,
      CSR_RELEASE_LATENCY  = 2'd3
   } flsa_csr_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_SCAN,
      ST_RETIRE,
      ST_INIT
   } flsa_state_type;

   // Request payload
   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [FENCE_W-1:0] fence;
      logic [SIZE_W-1:0]  request_size;
   } flsa_req_type;

   // Response payload
   typedef struct packed {
      logic [OUT_INDEX_W-1:0] buffer_index;
      logic [SIZE_W-1:0]      region_offset;
      logic                   new_buffer;
      logic                   table_full;
      logic                   buffer_released;
   } flsa_rsp_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic               retire;
      logic               init;
      logic [FENCE_W-1:0] fence;
      logic [SIZE_W-1:0]  req_size;
      logic [SIZE_W-1:0]  init_size;
      logic [SIZE_W-1:0]  grow_size;
      logic [IDLE_W-1:0]  latency;
   } flsa_cmd_type;

   // Per-cell position in the table
   typedef struct packed {
      logic live;
      logic last;
      logic init_en;
   } flsa_slot_type;

   // What a cell reports back; at most one cell reports a hit or append
   typedef struct packed {
      logic              hit;
      logic              append;
      logic              release_ok;
      logic [IDX_W-1:0]  index;
      logic [SIZE_W-1:0] offset;
   } flsa_report_type;

endpackage

// ----- sv/flsa_cell.sv -----
// One table entry of the sub-allocator: fence, bump offset, size and idle count.
// Takes the search token from its left neighbour and hands it on when it cannot serve.
// Depends on flsa_pkg.
module flsa_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [flsa_pkg::IDX_W-1:0]        cell_index,
   input  flsa_pkg::flsa_cmd_type            cmd,
   input  flsa_pkg::flsa_slot_type           slot,
   input  logic                              token_prev,
   output logic                              token_next,
   output flsa_pkg::flsa_report_type         report
);

   logic [flsa_pkg::FENCE_W-1:0] fence_ff,  fence_in;
   logic [flsa_pkg::SIZE_W-1:0]  offset_ff, offset_in;
   logic [flsa_pkg::SIZE_W-1:0]  size_ff,   size_in;
   logic [flsa_pkg::IDLE_W-1:0]  idle_ff,   idle_in;
   logic                         pass_ff,   pass_in;
   logic [flsa_pkg::SIZE_W:0]    end_sum;
   logic                         fits;

   // Fit test: fence not newer than the request and room without wrap
   assign end_sum = {1'b0, offset_ff} + {1'b0, cmd.req_size};
   assign fits    = (cmd.fence >= fence_ff) && (end_sum <= {1'b0, size_ff});

   // Serve, append or pass the token on; apply retire and initialise
   always_comb begin
      fence_in  = fence_ff;
      offset_in = offset_ff;
      size_in   = size_ff;
      idle_in   = idle_ff;
      pass_in   = 1'b0;
      report    = '0;

      if (token_prev) begin
         if (!slot.live) begin
            fence_in      = cmd.fence;
            offset_in     = cmd.req_size;
            size_in       = cmd.grow_size;
            idle_in       = '0;
            report.append = 1'b1;
            report.index  = cell_index;
         end else if (fits) begin
            fence_in      = cmd.fence;
            offset_in     = offset_ff + cmd.req_size;
            idle_in       = '0;
            report.hit    = 1'b1;
            report.index  = cell_index;
            report.offset = offset_ff;
         end else begin
            pass_in = 1'b1;
         end
      end

      if (cmd.retire && slot.live && (cmd.fence > fence_ff)) begin
         offset_in = '0;
         if (idle_ff != '1) begin
            idle_in = idle_ff + flsa_pkg::IDLE_W'(1);
         end
      end

      // Only the last live entry judges the release, on its updated idle count
      if (cmd.retire && slot.last && (idle_in >= cmd.latency)) begin
         report.release_ok = 1'b1;
      end

      if (cmd.init && slot.init_en) begin
         fence_in  = cmd.fence;
         offset_in = '0;
         size_in   = cmd.init_size;
         idle_in   = '0;
      end
   end

   assign token_next = pass_ff;

   // Token register
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= 1'b0;
      end else begin
         pass_ff <= pass_in;
      end
   end

   // Entry registers
   always_ff @(posedge clock) begin
      fence_ff  <= fence_in;
      offset_ff <= offset_in;
      size_ff   <= size_in;
      idle_ff   <= idle_in;
   end

endmodule

// ----- sv/fenced_linear_suballocator_core.sv -----
// Top level of the fenced linear sub-allocator: controller, registers and cell chain.
// Instantiates flsa_cell once per table entry; depends on flsa_pkg.
//
//   channel   handshake                 payload
//   request   start, busy               req_data  (flsa_req_type)
//   response  rsp_strobe                rsp_data  (flsa_rsp_type)
//   register  csr_write_enable          csr_index, csr_wdata
//
// Allocate: a token walks the cell chain one entry per cycle; busy stays high until
// an entry serves or appends the request, or the token leaves a full table.
// Retire and initialise return to idle from their own state; unused codes leave busy low.
// The response strobe rises at the edge where busy falls, or at the accepting edge
// itself for unused codes.
// Reset is synchronous and empties the table; no clearing pass is needed.
// The response is shown for one cycle only and cannot be held off.
module fenced_linear_suballocator_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  flsa_pkg::flsa_req_type               req_data,
   output logic                                 rsp_strobe,
   output flsa_pkg::flsa_rsp_type               rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [flsa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [flsa_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int N = flsa_pkg::MAX_BUFFERS;

   flsa_pkg::flsa_state_type                   state_ff, state_in;
   flsa_pkg::flsa_req_type                     req_ff, req_in;
   flsa_pkg::flsa_rsp_type                     rsp_ff, rsp_in;
   logic                                       rsp_valid_ff, rsp_valid_in;
   logic [flsa_pkg::COUNT_W-1:0]               count_ff, count_in;

   logic [flsa_pkg::INIT_NUM_W-1:0]            init_num_buffers_ff, init_num_buffers_in;
   logic [flsa_pkg::SIZE_W-1:0]                init_buffer_size_ff, init_buffer_size_in;
   logic [flsa_pkg::SIZE_W-1:0]                min_buffer_size_ff, min_buffer_size_in;
   logic [flsa_pkg::IDLE_W-1:0]                release_latency_ff, release_latency_in;

   flsa_pkg::flsa_cmd_type                     cmd;
   flsa_pkg::flsa_report_type                  reports [N];
   flsa_pkg::flsa_report_type                  merged;
   flsa_pkg::flsa_slot_type                    slots [N];
   logic [N:0]                                 chain;
   logic [flsa_pkg::SIZE_W-1:0]                init_size;
   logic [flsa_pkg::COUNT_W-1:0]               init_n;
   logic                                       released;

   // Decode register writes
   always_comb begin
      init_num_buffers_in = init_num_buffers_ff;
      init_buffer_size_in = init_buffer_size_ff;
      min_buffer_size_in  = min_buffer_size_ff;
      release_latency_in  = release_latency_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            flsa_pkg::CSR_INIT_NUM_BUFFERS:
               init_num_buffers_in = csr_wdata[flsa_pkg::INIT_NUM_W-1:0];
            flsa_pkg::CSR_INIT_BUFFER_SIZE:
               init_buffer_size_in = csr_wdata[flsa_pkg::SIZE_W-1:0];
            flsa_pkg::CSR_MIN_BUFFER_SIZE:
               min_buffer_size_in  = csr_wdata[flsa_pkg::SIZE_W-1:0];
            flsa_pkg::CSR_RELEASE_LATENCY:
               release_latency_in  = csr_wdata[flsa_pkg::IDLE_W-1:0];
            default: ;
         endcase
      end
   end

   // Sizes and initial count
   assign init_size = (min_buffer_size_ff > init_buffer_size_ff) ?
                      min_buffer_size_ff : init_buffer_size_ff;
   assign init_n    = (32'(init_num_buffers_ff) >= 32'(N)) ?
                      flsa_pkg::COUNT_W'(N) :
                      flsa_pkg::COUNT_W'(init_num_buffers_ff);

   // Broadcast command
   always_comb begin
      cmd.retire    = (state_ff == flsa_pkg::ST_RETIRE);
      cmd.init      = (state_ff == flsa_pkg::ST_INIT);
      cmd.fence     = req_ff.fence;
      cmd.req_size  = req_ff.request_size;
      cmd.init_size = init_size;
      cmd.grow_size = (req_ff.request_size > init_size) ? req_ff.request_size : init_size;
      cmd.latency   = release_latency_ff;
   end

   // Launch the token into the first cell
   assign chain[0] = (state_ff == flsa_pkg::ST_LAUNCH);

   // Cell chain
   for (genvar i = 0; i < N; i++) begin : g_cell
      always_comb begin
         slots[i].live    = (flsa_pkg::COUNT_W'(i) < count_ff);
         slots[i].last    = (count_ff != '0) &&
                            (flsa_pkg::COUNT_W'(i) == count_ff - flsa_pkg::COUNT_W'(1));
         slots[i].init_en = (flsa_pkg::COUNT_W'(i) < init_n);
      end

      flsa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (flsa_pkg::IDX_W'(i)),
         .cmd        (cmd),
         .slot       (slots[i]),
         .token_prev (chain[i]),
         .token_next (chain[i+1]),
         .report     (reports[i])
      );
   end

   // Merge cell reports; at most one cell serves at a time
   always_comb begin
      merged = '0;
      for (int k = 0; k < N; k++) begin
         merged = merged | reports[k];
      end
   end

   assign released = merged.release_ok &&
                     (32'(count_ff) > 32'(init_num_buffers_ff));

   // Next state and response
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      count_in     = count_ff;

      unique case (state_ff) inside
         flsa_pkg::ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               unique case (req_data.operation)
                  flsa_pkg::OP_ALLOCATE:   state_in = flsa_pkg::ST_LAUNCH;
                  flsa_pkg::OP_RETIRE:     state_in = flsa_pkg::ST_RETIRE;
                  flsa_pkg::OP_INITIALIZE: state_in = flsa_pkg::ST_INIT;
                  default: begin
                     rsp_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         flsa_pkg::ST_LAUNCH, flsa_pkg::ST_SCAN: begin
            if (merged.hit || merged.append) begin
               rsp_in               = '0;
               rsp_in.buffer_index  = flsa_pkg::OUT_INDEX_W'(merged.index);
               rsp_in.region_offset = merged.offset;
               rsp_in.new_buffer    = merged.append;
               rsp_valid_in         = 1'b1;
               state_in             = flsa_pkg::ST_IDLE;
               if (merged.append) begin
                  count_in = count_ff + flsa_pkg::COUNT_W'(1);
               end
            end else if (chain[N]) begin
               rsp_in            = '0;
               rsp_in.table_full = 1'b1;
               rsp_valid_in      = 1'b1;
               state_in          = flsa_pkg::ST_IDLE;
            end else begin
               state_in = flsa_pkg::ST_SCAN;
            end
         end
         flsa_pkg::ST_RETIRE: begin
            rsp_in                 = '0;
            rsp_in.buffer_released = released;
            rsp_valid_in           = 1'b1;
            state_in               = flsa_pkg::ST_IDLE;
            if (released) begin
               count_in = count_ff - flsa_pkg::COUNT_W'(1);
            end
         end
         flsa_pkg::ST_INIT: begin
            rsp_in       = '0;
            rsp_valid_in = 1'b1;
            count_in     = init_n;
            state_in     = flsa_pkg::ST_IDLE;
         end
         default: state_in = flsa_pkg::ST_IDLE;
      endcase
   end

   assign busy       = (state_ff != flsa_pkg::ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= flsa_pkg::ST_IDLE;
         rsp_valid_ff        <= 1'b0;
         count_ff            <= '0;
         init_num_buffers_ff <= flsa_pkg::INIT_NUM_BUFFERS_RST;
         init_buffer_size_ff <= flsa_pkg::INIT_BUFFER_SIZE_RST;
         min_buffer_size_ff  <= flsa_pkg::MIN_BUFFER_SIZE_RST;
         release_latency_ff  <= flsa_pkg::RELEASE_LATENCY_RST;
      end else begin
         state_ff            <= state_in;
         rsp_valid_ff        <= rsp_valid_in;
         count_ff            <= count_in;
         init_num_buffers_ff <= init_num_buffers_in;
         init_buffer_size_ff <= init_buffer_size_in;
         min_buffer_size_ff  <= min_buffer_size_in;
         release_latency_ff  <= release_latency_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ----- sv/flsa_checker.sv -----
// Port-level checks for the fenced linear sub-allocator, bound to its top level.
// Depends on flsa_pkg and fenced_linear_suballocator_core.
module flsa_port_checks (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input flsa_pkg::flsa_rsp_type rsp_data
);

   // A response is only given once the request has finished
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

   // An accepted request either occupies the block or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request neither started nor answered");

   // Busy rises only on an accepted request
   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

   // A full table answers with index and offset zero and no new entry
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.table_full) |->
         (rsp_data.buffer_index == '0 && rsp_data.region_offset == '0 &&
          !rsp_data.new_buffer))
      else $error("table full response carries data");

   // A newly appended entry always serves from offset zero
   a_new_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.new_buffer) |-> (rsp_data.region_offset == '0))
      else $error("new buffer with non-zero offset");

endmodule

bind fenced_linear_suballocator_core flsa_port_checks u_flsa_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
